// ===== sv/ktd_pkg.sv =====
// shared types and constants for the key text decoder
`timescale 1ns / 1ps

package ktd_pkg;

    localparam int KEY_LEN   = 20;
    localparam int COUNT_SAT = 21;

    localparam logic [4:0] LAST_POS   = 5'(KEY_LEN);
    localparam logic [4:0] COUNT_TOP  = 5'(COUNT_SAT);

    localparam logic [7:0] CHR_DASH   = 8'h2D;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_DIG_LO = 8'h32;
    localparam logic [7:0] CHR_DIG_HI = 8'h39;

    localparam logic [1:0] CLS_CONS  = 2'd0;
    localparam logic [1:0] CLS_VOWEL = 2'd1;
    localparam logic [1:0] CLS_DIGIT = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_CHR = 2'd2;

    typedef struct packed {
        logic       skip;
        logic       hit;
        logic [3:0] code;
        logic [2:0] nbits;
    } t_dec;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  check_byte;
        logic [55:0] key_value;
        logic [63:0] packed_word;
        logic        beta_flag;
    } t_result;

endpackage

// ===== sv/ktd_char_decode.sv =====
// class lookup: maps one character at a key position to its code and width
`timescale 1ns / 1ps

module ktd_char_decode
    import ktd_pkg::*;
(
    input  logic [7:0] i_char,
    input  logic [4:0] i_pos,
    output t_dec       o_dec
);

    logic [7:0] up_char;
    logic [1:0] cls;
    logic       cons_hit;
    logic [3:0] cons_code;
    logic       vow_hit;
    logic [1:0] vow_code;
    logic       dig_hit;
    logic [7:0] dig_diff;

    always_comb begin
        if (i_char >= 8'h61 && i_char <= 8'h7A) begin
            up_char = i_char - 8'h20;
        end else begin
            up_char = i_char;
        end
    end

    // first sixteen positions repeat consonant, vowel, consonant, digit
    always_comb begin
        if (i_pos >= 5'd16) begin
            cls = CLS_DIGIT;
        end else begin
            unique case (i_pos[1:0]) inside
                2'd0, 2'd2: cls = CLS_CONS;
                2'd1:       cls = CLS_VOWEL;
                default:    cls = CLS_DIGIT;
            endcase
        end
    end

    always_comb begin
        cons_hit  = 1'b1;
        cons_code = 4'd0;
        case (up_char)
            8'h42: cons_code = 4'd0;   // B
            8'h43: cons_code = 4'd1;   // C
            8'h44: cons_code = 4'd2;   // D
            8'h46: cons_code = 4'd3;   // F
            8'h47: cons_code = 4'd4;   // G
            8'h4A: cons_code = 4'd5;   // J
            8'h4C: cons_code = 4'd6;   // L
            8'h4D: cons_code = 4'd7;   // M
            8'h4E: cons_code = 4'd8;   // N
            8'h50: cons_code = 4'd9;   // P
            8'h52: cons_code = 4'd10;  // R
            8'h53: cons_code = 4'd11;  // S
            8'h54: cons_code = 4'd12;  // T
            8'h57: cons_code = 4'd13;  // W
            8'h58: cons_code = 4'd14;  // X
            8'h5A: cons_code = 4'd15;  // Z
            default: cons_hit = 1'b0;
        endcase
    end

    always_comb begin
        vow_hit  = 1'b1;
        vow_code = 2'd0;
        case (up_char)
            8'h41: vow_code = 2'd0;    // A
            8'h45: vow_code = 2'd1;    // E
            8'h55: vow_code = 2'd2;    // U
            8'h59: vow_code = 2'd3;    // Y
            default: vow_hit = 1'b0;
        endcase
    end

    assign dig_hit  = (i_char >= CHR_DIG_LO) && (i_char <= CHR_DIG_HI);
    assign dig_diff = i_char - CHR_DIG_LO;

    always_comb begin
        o_dec.skip = (i_char == CHR_DASH) || (i_char == CHR_SPACE) || (i_char == CHR_TAB);
        unique case (cls)
            CLS_CONS: begin
                o_dec.hit   = cons_hit;
                o_dec.code  = cons_code;
                o_dec.nbits = 3'd4;
            end
            CLS_VOWEL: begin
                o_dec.hit   = vow_hit;
                o_dec.code  = {2'b00, vow_code};
                o_dec.nbits = 3'd2;
            end
            default: begin
                o_dec.hit   = dig_hit;
                o_dec.code  = {1'b0, dig_diff[2:0]};
                o_dec.nbits = 3'd3;
            end
        endcase
    end

endmodule

// ===== sv/ktd_pack.sv =====
// packing state: count, bit offset, packed word and bad flag; forms the result
`timescale 1ns / 1ps

module ktd_pack
    import ktd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic [7:0] i_char,
    input  logic    i_last,
    output t_result o_result
);

    logic [4:0]  r_count;
    logic [6:0]  r_offset;
    logic [63:0] r_buf;
    logic        r_bad;

    logic [4:0]  n_count;
    logic [6:0]  n_offset;
    logic [63:0] n_buf;
    logic        n_bad;

    t_dec        dec;
    logic [63:0] shifted;
    logic [63:0] word;
    logic [1:0]  status;

    ktd_char_decode u_dec (
        .i_char (i_char),
        .i_pos  (r_count),
        .o_dec  (dec)
    );

    assign shifted = {60'd0, dec.code} << r_offset[5:0];

    always_comb begin
        n_count  = r_count;
        n_offset = r_offset;
        n_buf    = r_buf;
        n_bad    = r_bad;
        if (!dec.skip) begin
            if (r_count < LAST_POS) begin
                if (dec.hit) begin
                    n_buf    = r_buf | shifted;
                    n_offset = r_offset + {4'd0, dec.nbits};
                end else begin
                    n_bad = 1'b1;
                end
            end
            if (r_count < COUNT_TOP) begin
                n_count = r_count + 5'd1;
            end
        end
    end

    // length failure wins over a bad character
    always_comb begin
        if (n_count != LAST_POS) begin
            status = ST_BAD_LEN;
        end else if (n_bad) begin
            status = ST_BAD_CHR;
        end else begin
            status = ST_OK;
        end
        word = (status == ST_OK) ? n_buf : 64'd0;
        o_result.status      = status;
        o_result.check_byte  = word[31:24];
        o_result.key_value   = {word[63:32], word[23:0]};
        o_result.packed_word = word;
        o_result.beta_flag   = word[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_offset <= '0;
            r_buf    <= '0;
            r_bad    <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_count  <= '0;
                r_offset <= '0;
                r_buf    <= '0;
                r_bad    <= 1'b0;
            end else begin
                r_count  <= n_count;
                r_offset <= n_offset;
                r_buf    <= n_buf;
                r_bad    <= n_bad;
            end
        end
    end

endmodule

// ===== sv/key_text_decoder_core.sv =====
// top level of the key text decoder: input register, packing logic, result register
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  input   | in        | i_valid / o_stall  | i_char_code, i_last_char
//  result  | out       | o_valid / i_stall  | o_status, o_check_byte, o_key_value,
//          |           |                    | o_packed_word, o_beta_flag
//
// one character per cycle while o_stall is low; a transaction is held in the input register and
// updates the packing state as it leaves it
// the result of a last character is written to the result register at that same edge,
// so o_valid is registered behind both the input register and the result register
// synchronous active-low reset clears the packing state and both valid flags, not the data registers
// a stalled result only holds back a last character; other characters keep flowing
`timescale 1ns / 1ps

module key_text_decoder_core
    import ktd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_check_byte,
    output logic [55:0] o_key_value,
    output logic [63:0] o_packed_word,
    output logic        o_beta_flag
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       step;
    logic       take_in;
    t_result    result;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign o_stall  = r_in_valid && !step;
    assign take_in  = i_valid && !o_stall;

    ktd_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_check_byte  = r_out.check_byte;
    assign o_key_value   = r_out.key_value;
    assign o_packed_word = r_out.packed_word;
    assign o_beta_flag   = r_out.beta_flag;

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the key text decoder core
`timescale 1ns / 1ps

module tb_top
    import ktd_pkg::*;
();

    localparam int TEXT_ITEMS  = 1450;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [7:0] code;
        logic       is_last;
    } t_text_item;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [7:0]  i_char_code = 8'h00;
    logic        i_last_char = 1'b0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_check_byte;
    logic [55:0] o_key_value;
    logic [63:0] o_packed_word;
    logic        o_beta_flag;

    key_text_decoder_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_code  (i_char_code),
        .i_last_char  (i_last_char),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_check_byte (o_check_byte),
        .o_key_value  (o_key_value),
        .o_packed_word(o_packed_word),
        .o_beta_flag  (o_beta_flag)
    );

    always #5 i_clk = ~i_clk;

    string cons_letters  = "BCDFGJLMNPRSTWXZ";
    string vowel_letters = "AEUY";

    t_text_item text_queue[$];
    t_result    expected_keys[$];

    // decoder state mirror
    logic [4:0]  key_len_seen  = '0;
    logic [6:0]  pack_ofs      = '0;
    logic [63:0] pack_word     = '0;
    logic        saw_bad_char  = 1'b0;

    int n_total    = 0;
    int n_accepted = 0;
    int n_err      = 0;
    int n_results  = 0;
    int n_ok       = 0;
    int n_bad_len  = 0;
    int n_bad_chr  = 0;
    int cycle_cnt  = 0;

    function automatic logic is_skip(logic [7:0] c);
        return c == CHR_DASH || c == CHR_SPACE || c == CHR_TAB;
    endfunction

    function automatic logic [1:0] class_at(int pos);
        if (pos >= 16)
            return CLS_DIGIT;
        case (pos % 4)
            1:       return CLS_VOWEL;
            3:       return CLS_DIGIT;
            default: return CLS_CONS;
        endcase
    endfunction

    // code of c within its class, -1 when it does not belong there
    function automatic int char_value(logic [7:0] c, logic [1:0] cls);
        logic [7:0] up;
        up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        if (cls == CLS_CONS) begin
            for (int i = 0; i < 16; i++)
                if (up == cons_letters[i])
                    return i;
        end else if (cls == CLS_VOWEL) begin
            for (int i = 0; i < 4; i++)
                if (up == vowel_letters[i])
                    return i;
        end else if (c >= CHR_DIG_LO && c <= CHR_DIG_HI) begin
            return int'(c - CHR_DIG_LO);
        end
        return -1;
    endfunction

    function automatic int class_bits(logic [1:0] cls);
        case (cls)
            CLS_CONS:  return 4;
            CLS_VOWEL: return 2;
            default:   return 3;
        endcase
    endfunction

    task automatic decode_char_in(logic [7:0] c, logic is_last);
        int      code;
        t_result res;
        logic [63:0] w;
        if (!is_skip(c)) begin
            if (key_len_seen < LAST_POS) begin
                code = char_value(c, class_at(int'(key_len_seen)));
                if (code < 0) begin
                    saw_bad_char = 1'b1;
                end else begin
                    pack_word |= 64'(code) << pack_ofs[5:0];
                    pack_ofs  += 7'(class_bits(class_at(int'(key_len_seen))));
                end
            end
            if (key_len_seen < COUNT_TOP)
                key_len_seen++;
        end
        if (is_last) begin
            if (key_len_seen != LAST_POS)
                res.status = ST_BAD_LEN;
            else if (saw_bad_char)
                res.status = ST_BAD_CHR;
            else
                res.status = ST_OK;
            w = (res.status == ST_OK) ? pack_word : 64'd0;
            res.check_byte  = w[31:24];
            res.key_value   = {w[63:32], w[23:0]};
            res.packed_word = w;
            res.beta_flag   = w[0];
            expected_keys.push_back(res);
            key_len_seen = '0;
            pack_ofs     = '0;
            pack_word    = '0;
            saw_bad_char = 1'b0;
        end
    endtask

    // stimulus helpers
    function automatic logic [7:0] pick_skip();
        case ($urandom_range(2))
            0:       return CHR_DASH;
            1:       return CHR_SPACE;
            default: return CHR_TAB;
        endcase
    endfunction

    function automatic logic [7:0] pick_valid(logic [1:0] cls);
        logic [7:0] c;
        if (cls == CLS_CONS)
            c = cons_letters[$urandom_range(15)];
        else if (cls == CLS_VOWEL)
            c = vowel_letters[$urandom_range(3)];
        else
            return CHR_DIG_LO + 8'($urandom_range(7));
        return $urandom_range(1) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] pick_bad(logic [1:0] cls);
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_skip(c) || char_value(c, cls) >= 0);
        return c;
    endfunction

    task automatic push_char(logic [7:0] c, logic is_last);
        t_text_item it;
        it.code    = c;
        it.is_last = is_last;
        text_queue.push_back(it);
    endtask

    // one key text: n_chars significant characters, up to n_bad of them misfit
    task automatic add_text(int n_chars, int n_bad);
        t_text_item seq[$];
        t_text_item it;
        int span;
        int bad_a;
        int bad_b;
        span  = (n_chars < KEY_LEN) ? n_chars : KEY_LEN;
        bad_a = -1;
        bad_b = -1;
        if (n_bad > 0 && span > 0)
            bad_a = $urandom_range(span - 1);
        if (n_bad > 1 && span > 0)
            bad_b = $urandom_range(span - 1);
        it.is_last = 1'b0;
        for (int pos = 0; pos < n_chars; pos++) begin
            if ($urandom_range(99) < 12) begin
                it.code = pick_skip();
                seq.push_back(it);
            end
            if (pos == bad_a || pos == bad_b)
                it.code = pick_bad(class_at(pos % KEY_LEN));
            else
                it.code = pick_valid(class_at(pos % KEY_LEN));
            seq.push_back(it);
        end
        // a skip character may carry the last flag
        if (seq.size() == 0 || $urandom_range(99) < 10) begin
            it.code = pick_skip();
            seq.push_back(it);
        end
        seq[seq.size() - 1].is_last = 1'b1;
        foreach (seq[i])
            text_queue.push_back(seq[i]);
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(30, 1);
        for (int i = 0; i < n; i++)
            push_char(8'($urandom_range(255)), i == n - 1 || $urandom_range(99) < 3);
    endtask

    function automatic int tx_idle_pct();
        if (n_accepted * 3 < n_total)
            return 23;
        if (n_accepted * 3 < n_total * 2)
            return 84;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (n_accepted * 3 < n_total)
            return 84;
        if (n_accepted * 3 < n_total * 2)
            return 23;
        return 0;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
        n_err++;
        if (n_err <= 10)
            $display("mismatch on %s: expected %h, got %h at cycle %0d",
                     what, want_v, got_v, cycle_cnt);
    endtask

    // driver
    always @(posedge i_clk) begin : drv
        t_text_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                decode_char_in(i_char_code, i_last_char);
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (text_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct()) begin
                    it = text_queue.pop_front();
                    i_valid     <= 1'b1;
                    i_char_code <= it.code;
                    i_last_char <= it.is_last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin : mon
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (expected_keys.size() == 0) begin
                    flag_mismatch("unexpected transaction status", '0, 64'(o_status));
                end else begin
                    want = expected_keys.pop_front();
                    if (o_status != want.status)
                        flag_mismatch("status", 64'(want.status), 64'(o_status));
                    if (o_check_byte != want.check_byte)
                        flag_mismatch("check_byte", 64'(want.check_byte), 64'(o_check_byte));
                    if (o_key_value != want.key_value)
                        flag_mismatch("key_value", 64'(want.key_value), 64'(o_key_value));
                    if (o_packed_word != want.packed_word)
                        flag_mismatch("packed_word", want.packed_word, o_packed_word);
                    if (o_beta_flag != want.beta_flag)
                        flag_mismatch("beta_flag", 64'(want.beta_flag), 64'(o_beta_flag));
                    case (want.status)
                        ST_OK:      n_ok++;
                        ST_BAD_LEN: n_bad_len++;
                        default:    n_bad_chr++;
                    endcase
                end
            end
            i_stall <= ($urandom_range(99) < rx_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        int kind;
        // empty text, lone NUL, lone top byte
        push_char(CHR_DASH, 1'b1);
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        // all-ones key with mixed case and a dash inside
        for (int g = 0; g < 4; g++) begin
            push_char(g[0] ? "z" : "Z", 1'b0);
            push_char(g[1] ? "y" : "Y", 1'b0);
            push_char("Z", 1'b0);
            push_char("9", 1'b0);
            if (g == 0)
                push_char(CHR_DASH, 1'b0);
        end
        for (int i = 0; i < 4; i++)
            push_char("9", i == 3);

        while (text_queue.size() < TEXT_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 55)
                add_text(KEY_LEN, 0);
            else if (kind < 70)
                add_text(KEY_LEN, $urandom_range(2, 1));
            else if (kind < 80)
                add_text($urandom_range(1) ? $urandom_range(19) : $urandom_range(40, 21), 1);
            else if (kind < 90)
                add_text($urandom_range(1) ? $urandom_range(19) : $urandom_range(40, 21), 0);
            else
                add_noise();
        end
        n_total = text_queue.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_queue.size() > 0 || i_valid)
            @(posedge i_clk);
        while (expected_keys.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (expected_keys.size() > 0) begin
            n_err += expected_keys.size();
            $display("%0d expected results never arrived", expected_keys.size());
        end
        $display("%0d characters sent, %0d key results checked in %0d cycles",
                 n_accepted, n_results, cycle_cnt);
        $display("results: %0d ok, %0d wrong length, %0d bad character; %0d mismatches",
                 n_ok, n_bad_len, n_bad_chr, n_err);
        if (n_err == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
